// File: hdl/qrsd_pkg.sv
// ----------------------------------------------------------------------------
// qrsd_pkg - shared types and constants of the QR payload segment decoder
// Field widths, mode and status codes, the result word and the
// alphanumeric character table.
// ----------------------------------------------------------------------------
package qrsd_pkg;

	localparam int MSG_W    = 8;
	localparam int CHAR_W   = 8;
	localparam int STATUS_W = 2;

	// mode indicator codes
	localparam logic [3:0] MODE_ALNUM = 4'd2;
	localparam logic [3:0] MODE_BYTE  = 4'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TRUNCATED   = 2'd2;

	// most bits the buffer holds after a byte is appended (10 left + 8 new)
	localparam logic [4:0] HELD_MAX = 5'd18;

	// ceil(2^16 / 45): v/45 == (v * DIV45_RECIP) >> 16 for any 11-bit v
	localparam logic [21:0] DIV45_RECIP = 22'd1457;

	typedef struct packed {
		logic              char_valid;
		logic [CHAR_W-1:0] character;
		logic [STATUS_W-1:0] status;
		logic              done_res;
	} result_t;

	// alphanumeric code to ASCII, '?' for codes past the table
	function automatic logic [7:0] alnum_char(input logic [5:0] v);
		logic [7:0] c;
		case (v) inside
			[6'd0:6'd9]:   c = 8'h30 + 8'(v);
			[6'd10:6'd35]: c = 8'h37 + 8'(v);
			6'd36:         c = 8'h20;
			6'd37:         c = 8'h24;
			6'd38:         c = 8'h25;
			6'd39:         c = 8'h2A;
			6'd40:         c = 8'h2B;
			6'd41:         c = 8'h2D;
			6'd42:         c = 8'h2E;
			6'd43:         c = 8'h2F;
			6'd44:         c = 8'h3A;
			default:       c = 8'h3F;
		endcase
		return c;
	endfunction

endpackage

// File: hdl/qrsd_in_if.sv
// ----------------------------------------------------------------------------
// qrsd_in_if - message byte channel
// Valid/ready channel carrying one message byte and its last flag per word.
// ----------------------------------------------------------------------------
interface qrsd_in_if import qrsd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [MSG_W-1:0] message_byte;
	logic             last_byte;

	modport source(output valid, message_byte, last_byte, input ready);
	modport sink(input valid, message_byte, last_byte, output ready);
endinterface

// File: hdl/qrsd_out_if.sv
// ----------------------------------------------------------------------------
// qrsd_out_if - decoded result channel
// Valid/ready channel carrying one decoded character or status per word.
// ----------------------------------------------------------------------------
interface qrsd_out_if import qrsd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                char_valid;
	logic [CHAR_W-1:0]   character;
	logic [STATUS_W-1:0] status;
	logic                done_res;

	modport source(output valid, char_valid, character, status, done_res, input ready);
	modport sink(input valid, char_valid, character, status, done_res, output ready);
endinterface

// File: hdl/qr_payload_segment_decoder.sv
// ----------------------------------------------------------------------------
// qr_payload_segment_decoder - QR byte / alphanumeric segment decoder
// Reads corrected message bytes MSB first and emits decoded characters.
// ----------------------------------------------------------------------------
// Usage:
//   message: one corrected message byte per word, last_byte on the final one.
//   result : one word per decoded character, or a status word (unsupported
//            mode, truncated message, or an empty count); done_res marks the
//            final word of a message. Bytes after completion give no words.
// Path: a taken byte is captured in the input register, decoded from there,
//   and its result words are loaded into the result buffer once it has room.
// Throughput: one byte per cycle while each byte yields at most one word
//   and result.ready is high. A byte yields up to three words (an 11-bit
//   alphanumeric pair plus an odd character or a truncation status); the
//   buffer drains them one per ready cycle, holding the input stage meanwhile.
// Stall: with result.ready low a non-empty result buffer holds, the byte
//   waits in the input register and message.ready drops once that is full.
// Reset: arst_n clears the bit buffer, count and phase at once; no
//   initialization pass, the first byte may follow right after release.
// After a byte flagged last, all decode state returns to its reset values.
// ----------------------------------------------------------------------------
module qr_payload_segment_decoder import qrsd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	qrsd_in_if.sink    message,
	qrsd_out_if.source result
);

	typedef enum logic [2:0] {
		PH_HEADER   = 3'd0,
		PH_COUNT    = 3'd1,
		PH_CHARS    = 3'd2,
		PH_FINISHED = 3'd3
	} phase_t;

	// input register stage
	logic             valid_s1;
	logic [MSG_W-1:0] byte_s1;
	logic             last_s1;

	// decode state
	logic [23:0] buf_q;
	logic [4:0]  held_q;
	phase_t      phase_q;
	logic        alnum_q;
	logic [8:0]  left_q;

	// result buffer: slot 0 is the word on the output
	result_t     res_q [3];
	logic [1:0]  res_left_q;

	// next-state values from the decode logic
	logic [23:0] buf_d;
	logic [4:0]  held_d;
	phase_t      phase_d;
	logic        alnum_d;
	logic [8:0]  left_d;
	result_t     res_d [3];
	logic [1:0]  res_n_d;

	logic buf_free;
	logic s1_adv;
	logic in_take;
	logic out_take;

	function automatic logic [23:0] low_mask(input logic [4:0] k);
		return (24'd1 << k) - 24'd1;
	endfunction

	// top w bits of the valid part of the buffer
	function automatic logic [10:0] peek(input logic [23:0] b, input logic [4:0] h,
			input logic [4:0] w);
		logic [23:0] sh;
		sh = (b >> (h - w)) & low_mask(w);
		return sh[10:0];
	endfunction

	function automatic result_t mk_res(input logic v, input logic [CHAR_W-1:0] c,
			input logic [STATUS_W-1:0] st, input logic d);
		result_t r;
		r.char_valid = v;
		r.character  = c;
		r.status     = st;
		r.done_res   = d;
		return r;
	endfunction

	assign out_take      = res_left_q != 2'd0 && result.ready;
	assign buf_free      = res_left_q == 2'd0 || (res_left_q == 2'd1 && result.ready);
	assign s1_adv        = valid_s1 && buf_free;
	assign message.ready = !valid_s1 || s1_adv;
	assign in_take       = message.valid && message.ready;

	assign result.valid      = res_left_q != 2'd0;
	assign result.char_valid = res_q[0].char_valid;
	assign result.character  = res_q[0].character;
	assign result.status     = res_q[0].status;
	assign result.done_res   = res_q[0].done_res;

	// Decode of one byte. Header and count never both complete on one byte,
	// and at most two character fields fit in 18 bits, so three character
	// passes cover every case (the last one only sees the count run out).
	always_comb begin : decode
		logic [23:0] b;
		logic [4:0]  h;
		phase_t      ph;
		logic        am;
		logic [8:0]  lf;
		logic [1:0]  n;
		logic [10:0] f;
		logic [4:0]  w;
		logic [21:0] prod;
		logic [5:0]  q;
		logic [10:0] rm;

		b    = buf_q;
		h    = held_q;
		ph   = phase_q;
		am   = alnum_q;
		lf   = left_q;
		n    = 2'd0;
		f    = '0;
		prod = '0;
		q    = '0;
		rm   = '0;
		for (int i = 0; i < 3; i++) begin
			res_d[i] = '0;
		end

		if (ph == PH_HEADER || ph == PH_COUNT || ph == PH_CHARS) begin
			b = {b[15:0], byte_s1};
			h = h + 5'd8;
		end

		// mode header
		if (ph == PH_HEADER && h >= 5'd4) begin
			f = peek(b, h, 5'd4);
			h = h - 5'd4;
			b = b & low_mask(h);
			if (f[3:0] == MODE_BYTE) begin
				am = 1'b0;
				ph = PH_COUNT;
			end else if (f[3:0] == MODE_ALNUM) begin
				am = 1'b1;
				ph = PH_COUNT;
			end else begin
				res_d[n] = mk_res(1'b0, '0, ST_UNSUPPORTED, 1'b1);
				n = n + 2'd1;
				ph = PH_FINISHED;
			end
		end

		// character count
		w = am ? 5'd9 : 5'd8;
		if (ph == PH_COUNT && h >= w) begin
			f  = peek(b, h, w);
			lf = f[8:0];
			h  = h - w;
			b  = b & low_mask(h);
			ph = PH_CHARS;
		end

		// character fields
		for (int i = 0; i < 3; i++) begin
			if (ph == PH_CHARS) begin
				if (lf == 9'd0) begin
					if (n != 2'd0) begin
						res_d[n - 2'd1].done_res = 1'b1;
					end else begin
						res_d[n] = mk_res(1'b0, '0, ST_OK, 1'b1);
						n = n + 2'd1;
					end
					ph = PH_FINISHED;
				end else if (!am) begin
					if (h >= 5'd8) begin
						f = peek(b, h, 5'd8);
						h = h - 5'd8;
						b = b & low_mask(h);
						if (n < 2'd3) begin
							res_d[n] = mk_res(1'b1, f[7:0], ST_OK, 1'b0);
							n = n + 2'd1;
						end
						lf = lf - 9'd1;
					end
				end else if (lf >= 9'd2) begin
					if (h >= 5'd11) begin
						f    = peek(b, h, 5'd11);
						h    = h - 5'd11;
						b    = b & low_mask(h);
						prod = 22'(f) * DIV45_RECIP;
						q    = prod[21:16];
						rm   = f - 11'(q) * 11'd45;
						if (n < 2'd3) begin
							res_d[n] = mk_res(1'b1, alnum_char(q), ST_OK, 1'b0);
							n = n + 2'd1;
						end
						if (n < 2'd3) begin
							res_d[n] = mk_res(1'b1, alnum_char(rm[5:0]), ST_OK, 1'b0);
							n = n + 2'd1;
						end
						lf = lf - 9'd2;
					end
				end else begin
					if (h >= 5'd6) begin
						f = peek(b, h, 5'd6);
						h = h - 5'd6;
						b = b & low_mask(h);
						if (n < 2'd3) begin
							res_d[n] = mk_res(1'b1, alnum_char(f[5:0]), ST_OK, 1'b0);
							n = n + 2'd1;
						end
						lf = lf - 9'd1;
					end
				end
			end
		end

		// end of message: flag a short message, then start over
		if (last_s1) begin
			if ((ph == PH_HEADER || ph == PH_COUNT || ph == PH_CHARS) && n < 2'd3) begin
				res_d[n] = mk_res(1'b0, '0, ST_TRUNCATED, 1'b1);
				n = n + 2'd1;
			end
			b  = '0;
			h  = '0;
			ph = PH_HEADER;
			am = 1'b0;
			lf = '0;
		end

		buf_d   = b;
		held_d  = h;
		phase_d = ph;
		alnum_d = am;
		left_d  = lf;
		res_n_d = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			byte_s1    <= '0;
			last_s1    <= 1'b0;
			buf_q      <= '0;
			held_q     <= '0;
			phase_q    <= PH_HEADER;
			alnum_q    <= 1'b0;
			left_q     <= '0;
			res_left_q <= '0;
			for (int i = 0; i < 3; i++) begin
				res_q[i] <= '0;
			end
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
				byte_s1  <= message.message_byte;
				last_s1  <= message.last_byte;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end

			if (s1_adv) begin
				buf_q      <= buf_d;
				held_q     <= held_d;
				phase_q    <= phase_d;
				alnum_q    <= alnum_d;
				left_q     <= left_d;
				res_left_q <= res_n_d;
				for (int i = 0; i < 3; i++) begin
					res_q[i] <= res_d[i];
				end
			end else if (out_take) begin
				res_q[0]   <= res_q[1];
				res_q[1]   <= res_q[2];
				res_left_q <= res_left_q - 2'd1;
			end
		end
	end

	// the buffer never holds more than one partial field plus a byte
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HELD_MAX)
		else $error("bit buffer holds more bits than a field plus a byte");

	// a byte flagged last leaves the decoder ready for a new message
	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && last_s1 |=> phase_q == PH_HEADER && held_q == 5'd0 && left_q == 9'd0)
		else $error("decode state not cleared after last byte");

	// a finished message ignores further bytes until its last one
	a_finished_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && !last_s1 && phase_q == PH_FINISHED
		|=> phase_q == PH_FINISHED && $stable(held_q))
		else $error("finished message changed state on an ignored byte");

	// a decoded byte only waits while earlier words are pending
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |-> res_left_q != 2'd0)
		else $error("input stage stalled with an empty result buffer");

endmodule

// File: verif/qrsd_decode_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrsd_decode_check_pkg - expected-character tracker for the segment decoder
// Follows the decoder's bitstream state for every accepted message byte,
// queues the result words it must produce and compares returned words.
// ----------------------------------------------------------------------------
package qrsd_decode_check_pkg;
	import qrsd_pkg::*;

	class segment_decode_checker;
		typedef enum logic [2:0] {PH_HEADER, PH_COUNT, PH_CHARS, PH_DONE} phase_e;

		logic [23:0] bit_buf;
		logic [4:0]  held;
		phase_e      phase;
		logic        alnum;
		logic [8:0]  chars_left;

		result_t pending_words[$];
		result_t step_words[$];
		int      mismatch_count;

		function new();
			clear();
			mismatch_count = 0;
		endfunction

		function void clear();
			bit_buf    = '0;
			held       = '0;
			phase      = PH_HEADER;
			alnum      = 1'b0;
			chars_left = '0;
		endfunction

		// take n bits off the top of the held bits
		function int unsigned pull(int unsigned n);
			int unsigned v;
			v = (32'(bit_buf) >> (32'(held) - n)) & ((32'd1 << n) - 1);
			held = held - 5'(n);
			bit_buf = bit_buf & 24'((32'd1 << held) - 1);
			return v;
		endfunction

		function logic [7:0] alnum_ascii(int unsigned code);
			string glyphs = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ $%*+-./:";
			if (code < 45) begin
				return glyphs[code];
			end
			return "?";
		endfunction

		// at most three words per byte
		function void add_word(logic cv, logic [7:0] ch, logic [1:0] st, logic dn);
			result_t w;
			if (step_words.size() >= 3) begin
				return;
			end
			w.char_valid = cv;
			w.character  = ch;
			w.status     = st;
			w.done_res   = dn;
			step_words = {step_words, w};
		endfunction

		function void take_byte(logic [7:0] b, logic is_last);
			int unsigned v;
			int unsigned w;
			bit stop;
			step_words.delete();
			if (phase != PH_DONE) begin
				bit_buf = {bit_buf[15:0], b};
				held = held + 5'd8;
			end
			stop = 1'b0;
			while (!stop) begin
				case (phase)
					PH_HEADER: begin
						if (held < 4) begin
							stop = 1'b1;
						end else begin
							v = pull(4);
							if (v[3:0] == MODE_BYTE) begin
								alnum = 1'b0;
								phase = PH_COUNT;
							end else if (v[3:0] == MODE_ALNUM) begin
								alnum = 1'b1;
								phase = PH_COUNT;
							end else begin
								add_word(1'b0, 8'd0, ST_UNSUPPORTED, 1'b1);
								phase = PH_DONE;
								stop = 1'b1;
							end
						end
					end
					PH_COUNT: begin
						w = alnum ? 9 : 8;
						if (held < w) begin
							stop = 1'b1;
						end else begin
							chars_left = 9'(pull(w));
							phase = PH_CHARS;
						end
					end
					PH_CHARS: begin
						if (chars_left == 0) begin
							// count used up: flag the last word of this byte, or a bare done
							if (step_words.size() > 0) begin
								step_words[step_words.size() - 1].done_res = 1'b1;
							end else begin
								add_word(1'b0, 8'd0, ST_OK, 1'b1);
							end
							phase = PH_DONE;
							stop = 1'b1;
						end else if (!alnum) begin
							if (held < 8) begin
								stop = 1'b1;
							end else begin
								add_word(1'b1, 8'(pull(8)), ST_OK, 1'b0);
								chars_left = chars_left - 9'd1;
							end
						end else if (chars_left >= 2) begin
							if (held < 11) begin
								stop = 1'b1;
							end else begin
								v = pull(11);
								add_word(1'b1, alnum_ascii(v / 45), ST_OK, 1'b0);
								add_word(1'b1, alnum_ascii(v % 45), ST_OK, 1'b0);
								chars_left = chars_left - 9'd2;
							end
						end else begin
							if (held < 6) begin
								stop = 1'b1;
							end else begin
								add_word(1'b1, alnum_ascii(pull(6)), ST_OK, 1'b0);
								chars_left = chars_left - 9'd1;
							end
						end
					end
					default: begin
						stop = 1'b1;
					end
				endcase
			end
			if (is_last) begin
				if (phase != PH_DONE) begin
					add_word(1'b0, 8'd0, ST_TRUNCATED, 1'b1);
				end
				clear();
			end
			foreach (step_words[i]) begin
				pending_words = {pending_words, step_words[i]};
			end
		endfunction

		function void check_word(result_t got);
			result_t want;
			if (pending_words.size() == 0) begin
				$error("result word with none expected: char_valid=%0d character=%02h status=%0d done_res=%0d",
					got.char_valid, got.character, got.status, got.done_res);
				mismatch_count++;
				return;
			end
			want = pending_words.pop_front();
			if (got.char_valid !== want.char_valid) begin
				$error("char_valid: expected %0d, got %0d", want.char_valid, got.char_valid);
				mismatch_count++;
			end
			if (got.character !== want.character) begin
				$error("character: expected %02h, got %02h", want.character, got.character);
				mismatch_count++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatch_count++;
			end
			if (got.done_res !== want.done_res) begin
				$error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
				mismatch_count++;
			end
		endfunction

		function int outstanding();
			return pending_words.size();
		endfunction
	endclass

endpackage

// File: verif/qr_payload_segment_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qr_payload_segment_decoder_tb - testbench of the QR segment decoder
// Feeds message bytes built from byte-mode, alphanumeric, unsupported,
// truncated and noise messages, predicts every result word per accepted
// byte and checks the returned words in order, under random back-pressure.
// ----------------------------------------------------------------------------
module qr_payload_segment_decoder_tb import qrsd_pkg::*, qrsd_decode_check_pkg::*;;

	// mode codes the decoder does not support
	localparam logic [3:0] MODE_TERM = 4'd0;
	localparam logic [3:0] MODE_RSVD = 4'hF;

	localparam int RANDOM_ITEMS   = 400;
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
	localparam int DRAIN_CYCLES   = 16;    // extra wait after the last predicted word, for strays

	logic clk;
	logic arst_n;

	qrsd_in_if  message_if();
	qrsd_out_if result_if();

	qr_payload_segment_decoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.message(message_if),
		.result (result_if)
	);

	segment_decode_checker seg_check;

	bit stream_bits[$];     // message under construction, MSB first
	int content_items;      // bytes sent that carry message content
	int send_idle_pct;
	int recv_stall_pct;
	int stall_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver side: ready re-rolled every cycle. One NBA per edge.
	always @(posedge clk) begin
		result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Every accepted result word goes straight to the tracker.
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			seg_check.check_word({result_if.char_valid, result_if.character,
				result_if.status, result_if.done_res});
		end
	end

	// Watchdog: a hang shows up as a long run of edges where no word moves.
	always @(posedge clk) begin
		if (!arst_n || (message_if.valid && message_if.ready)
				|| (result_if.valid && result_if.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic void push_field(int unsigned value, int width);
		for (int i = width - 1; i >= 0; i--) begin
			stream_bits = {stream_bits, value[i]};
		end
	endfunction

	// One byte on the message channel. Idle cycles come first; valid stays
	// high straight into the next byte when no idle is rolled.
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			message_if.valid <= 1'b0;
			@(posedge clk);
		end
		message_if.valid        <= 1'b1;
		message_if.message_byte <= b;
		message_if.last_byte    <= is_last;
		do @(posedge clk); while (!message_if.ready);
		seg_check.take_byte(b, is_last);
	endtask

	// Pack the built bitstream into bytes (random fill in the tail byte),
	// optionally cut it to keep_bytes, add ignored trailing bytes, and send
	// it with last on the final byte.
	task automatic ship_message(input int keep_bytes, input int extra_bytes);
		logic [7:0] bytes_q[$];
		logic [7:0] acc;
		acc = '0;
		while (stream_bits.size() % 8 != 0) begin
			stream_bits = {stream_bits, 1'($urandom_range(0, 1))};
		end
		foreach (stream_bits[i]) begin
			acc = {acc[6:0], stream_bits[i]};
			if (i % 8 == 7) begin
				bytes_q = {bytes_q, acc};
			end
		end
		if (keep_bytes > 0) begin
			while (bytes_q.size() > keep_bytes) begin
				void'(bytes_q.pop_back());
			end
		end
		content_items += bytes_q.size();
		repeat (extra_bytes) bytes_q = {bytes_q, 8'($urandom)};
		foreach (bytes_q[i]) begin
			send_byte(bytes_q[i], i == bytes_q.size() - 1);
		end
		stream_bits.delete();
	endtask

	initial begin
		int unsigned kind;
		int unsigned count;
		int unsigned body;
		int unsigned mode;
		int          noise_len;

		arst_n                  = 1'b0;
		message_if.valid        = 1'b0;
		message_if.message_byte = '0;
		message_if.last_byte   = 1'b0;
		content_items           = 0;
		send_idle_pct           = 36;
		recv_stall_pct          = 84;
		seg_check               = new();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed ----
		// terminator mode: unsupported, nothing else
		push_field(MODE_TERM, 4);
		ship_message(0, 0);
		// all-ones mode, then a byte the decoder must ignore
		push_field(MODE_RSVD, 4);
		ship_message(0, 1);
		// byte mode, empty count: bare done word
		push_field(MODE_BYTE, 4);
		push_field(0, 8);
		ship_message(0, 0);
		// byte mode, both extreme characters, then an ignored byte
		push_field(MODE_BYTE, 4);
		push_field(2, 8);
		push_field(8'h00, 8);
		push_field(8'hFF, 8);
		ship_message(0, 1);
		// alphanumeric, empty count
		push_field(MODE_ALNUM, 4);
		push_field(0, 9);
		ship_message(0, 0);
		// alphanumeric pair with quotient past the table, odd char past it too
		push_field(MODE_ALNUM, 4);
		push_field(3, 9);
		push_field(2047, 11);
		push_field(63, 6);
		ship_message(0, 0);
		// alphanumeric, top table entry in both halves and in the odd char
		push_field(MODE_ALNUM, 4);
		push_field(3, 9);
		push_field(2024, 11);
		push_field(44, 6);
		ship_message(0, 0);
		// largest alphanumeric count, message ends before the count is read
		push_field(MODE_ALNUM, 4);
		push_field(511, 9);
		ship_message(1, 0);
		// largest byte count, one character then the message ends
		push_field(MODE_BYTE, 4);
		push_field(255, 8);
		push_field(8'hA5, 8);
		ship_message(0, 0);

		// ---- random, three idle profiles ----
		content_items = 0;
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle_pct  = 36;
					recv_stall_pct = 84;
				end
				1: begin
					send_idle_pct  = 84;
					recv_stall_pct = 36;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			while (content_items < (p + 1) * RANDOM_ITEMS / 3) begin
				kind = $urandom_range(0, 99);
				if (kind < 40) begin
					// complete byte-mode message, maybe trailing junk
					count = $urandom_range(0, 16);
					push_field(MODE_BYTE, 4);
					push_field(count, 8);
					repeat (count) push_field($urandom_range(0, 255), 8);
					ship_message(0, $urandom_range(0, 2));
				end else if (kind < 75) begin
					// complete alphanumeric message; some pairs decode to '?'
					count = $urandom_range(0, 20);
					push_field(MODE_ALNUM, 4);
					push_field(count, 9);
					repeat (count / 2) begin
						push_field(($urandom_range(0, 7) == 0) ? $urandom_range(2025, 2047)
							: $urandom_range(0, 2024), 11);
					end
					if (count % 2) begin
						push_field($urandom_range(0, 63), 6);
					end
					ship_message(0, $urandom_range(0, 2));
				end else if (kind < 83) begin
					// unsupported mode
					do mode = $urandom_range(0, 15);
					while (mode == MODE_BYTE || mode == MODE_ALNUM);
					push_field(mode, 4);
					ship_message(0, $urandom_range(0, 2));
				end else if (kind < 93) begin
					// count larger than the body sent: ends early (tail fill may
					// still complete it, the tracker follows either way)
					if ($urandom_range(0, 1)) begin
						count = $urandom_range(1, 255);
						body = $urandom_range(0, (count > 10) ? 10 : count - 1);
						push_field(MODE_BYTE, 4);
						push_field(count, 8);
						repeat (body) push_field($urandom_range(0, 255), 8);
					end else begin
						count = $urandom_range(1, 511);
						body = $urandom_range(0, (count > 10) ? 10 : count - 1);
						push_field(MODE_ALNUM, 4);
						push_field(count, 9);
						repeat (body / 2) push_field($urandom_range(0, 2047), 11);
						if (body % 2) begin
							push_field($urandom_range(0, 63), 6);
						end
					end
					ship_message(($urandom_range(0, 3) == 0) ? 1 : 0, 0);
				end else begin
					// noise, with stray last flags; always closes the message
					noise_len = $urandom_range(0, 3);
					repeat (noise_len) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
					send_byte(8'($urandom), 1'b1);
					content_items += noise_len + 1;
				end
			end
		end

		message_if.valid <= 1'b0;

		// wait for every predicted word, then drain for strays
		while (seg_check.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (seg_check.mismatch_count == 0 && seg_check.outstanding() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/qrsd_pkg.sv
hdl/qrsd_in_if.sv
hdl/qrsd_out_if.sv
hdl/qr_payload_segment_decoder.sv
verif/qrsd_decode_check_pkg.sv
verif/qr_payload_segment_decoder_tb.sv
